FILE: hdl/mpba_pkg.sv
// Shared constants and codes of the multi-pool block allocator.
package mpba_pkg;

  localparam int NUM_POOLS_DEF    = 4;
  localparam int MAX_BLOCKS_DEF   = 256;
  localparam int HEADER_BYTES_DEF = 8;

  localparam int SIZE_W   = 16;
  localparam int COUNT_W  = 9;
  localparam int POOL_W   = 2;
  localparam int INDEX_W  = 8;
  localparam int STATUS_W = 2;
  localparam int OFFSET_W = 27;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_BLOCK = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

endpackage

FILE: hdl/mpba_if.sv
// Channel interfaces: request, response and configuration write.
interface mpba_req_if import mpba_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                command;
  logic [SIZE_W-1:0]   request_size;
  logic [POOL_W-1:0]   free_pool;
  logic [INDEX_W-1:0]  free_index;
  modport source(output valid, command, request_size, free_pool, free_index, input ready);
  modport sink(input valid, command, request_size, free_pool, free_index, output ready);
endinterface

interface mpba_rsp_if import mpba_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [OFFSET_W-1:0] block_offset;
  logic [POOL_W-1:0]   granted_pool;
  logic [INDEX_W-1:0]  granted_index;
  modport source(output valid, status, block_offset, granted_pool, granted_index, input ready);
  modport sink(input valid, status, block_offset, granted_pool, granted_index, output ready);
endinterface

interface mpba_cfg_if import mpba_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: hdl/multi_pool_block_allocator.sv
// Multi-pool fixed-size block allocator with per-pool FIFO free rings.
//
//   channel  role  word
//   req      sink  command, request_size, free_pool, free_index
//   rsp      src   status, block_offset, granted_pool, granted_index
//   cfg      sink  index, data (ready always high)
//
// Allocate: SCAN over the pools, RDWAIT on a ring read, then MUL, ADD and FIN; a miss
// goes from SCAN to FIN; free: FREE, then FIN.
// The scan steps one pool a cycle through one compare unit; one shared multiplier
// forms the offset. A config write rebuilds pool bases (REB_MUL, REB_ADD), req not ready.
// Reset is synchronous; a new request is taken while a result waits on rsp.
module multi_pool_block_allocator import mpba_pkg::*; #(
  parameter int NUM_POOLS    = NUM_POOLS_DEF,
  parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input logic       clk,
  input logic       rst,
  mpba_req_if.sink  req,
  mpba_rsp_if.source rsp,
  mpba_cfg_if.sink  cfg
);

  localparam int PW    = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int IW    = $clog2(MAX_BLOCKS);
  localparam int CW    = $clog2(MAX_BLOCKS + 1);
  localparam int AW    = $clog2(NUM_POOLS * MAX_BLOCKS);
  localparam int DEPTH = NUM_POOLS * MAX_BLOCKS;
  localparam int MA_W  = SIZE_W + 1;
  localparam int PR_W  = MA_W + CW;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_SCAN    = 9'b000000010,
    S_RDWAIT  = 9'b000000100,
    S_MUL     = 9'b000001000,
    S_ADD     = 9'b000010000,
    S_FREE    = 9'b000100000,
    S_FIN     = 9'b001000000,
    S_REB_MUL = 9'b010000000,
    S_REB_ADD = 9'b100000000
  } state_t;

  state_t state;

  logic [SIZE_W-1:0]   size_r  [NUM_POOLS];
  logic [COUNT_W-1:0]  count_r [NUM_POOLS];
  logic [OFFSET_W-1:0] base    [NUM_POOLS];
  logic [IW-1:0]       head    [NUM_POOLS];
  logic [CW-1:0]       fill    [NUM_POOLS];
  logic [CW-1:0]       fresh   [NUM_POOLS];
  logic [CW-1:0]       eff     [NUM_POOLS];
  logic [NUM_POOLS-1:0] act;

  logic [IW-1:0] ring [DEPTH];
  logic [IW-1:0] ring_rdata;
  logic          ring_we, ring_re;
  logic [AW-1:0] ring_waddr, ring_raddr;

  logic [PW:0]         pidx;
  logic [PW-1:0]       p;
  logic [SIZE_W-1:0]   want;
  logic [INDEX_W-1:0]  fidx;
  logic                bad_pool;
  logic [CW-1:0]       idx;
  logic [PR_W-1:0]     prod;
  logic [OFFSET_W-1:0] acc;

  logic [MA_W-1:0] mul_a;
  logic [CW-1:0]   mul_b;

  logic [STATUS_W-1:0] res_status;
  logic [OFFSET_W-1:0] res_offset;
  logic [POOL_W-1:0]   res_pool;
  logic [INDEX_W-1:0]  res_index;

  logic                ovalid;
  logic [STATUS_W-1:0] ostatus;
  logic [OFFSET_W-1:0] ooffset;
  logic [POOL_W-1:0]   opool;
  logic [INDEX_W-1:0]  oindex;

  logic        cfg_hit;
  logic        scan_end, fit, use_fresh, use_ring, free_ok;
  logic [31:0] nfree, tail32, head_inc;

  assign p = pidx[PW-1:0];

  always_comb begin
    logic live;
    live = 1'b1;
    for (int i = 0; i < NUM_POOLS; i++) begin
      eff[i] = (32'(count_r[i]) > MAX_BLOCKS) ? CW'(MAX_BLOCKS) : CW'(count_r[i]);
      live   = live && (size_r[i] != '0);
      act[i] = live;
    end
  end

  assign scan_end  = (32'(pidx) >= NUM_POOLS) || !act[p];
  assign fit       = size_r[p] >= want;
  assign use_fresh = fit && (fresh[p] < eff[p]);
  assign use_ring  = fit && (fill[p] != '0);
  assign nfree     = 32'(eff[p]) - 32'(fresh[p]) + 32'(fill[p]);
  assign free_ok   = !bad_pool && act[p] && (32'(fidx) < 32'(eff[p]))
                     && (32'(fidx) < 32'(fresh[p])) && (nfree < 32'(eff[p]));
  assign tail32    = (32'(head[p]) + 32'(fill[p]) >= MAX_BLOCKS)
                     ? 32'(head[p]) + 32'(fill[p]) - MAX_BLOCKS
                     : 32'(head[p]) + 32'(fill[p]);
  assign head_inc  = (32'(head[p]) + 1 >= MAX_BLOCKS) ? 32'd0 : 32'(head[p]) + 1;

  assign ring_we    = (state == S_FREE) && free_ok;
  assign ring_waddr = AW'(32'(p) * MAX_BLOCKS + tail32);
  assign ring_re    = (state == S_SCAN) && !scan_end && !use_fresh && use_ring;
  assign ring_raddr = AW'(32'(p) * MAX_BLOCKS + 32'(head[p]));

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[ring_waddr] <= IW'(32'(fidx));
    end
    if (ring_re) begin
      ring_rdata <= ring[ring_raddr];
    end
  end

  assign mul_a = MA_W'(size_r[p]) + MA_W'(HEADER_BYTES);
  assign mul_b = (state == S_REB_MUL) ? eff[p] : idx;

  assign cfg_hit = cfg.valid && (32'(cfg.index) < 2 * NUM_POOLS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
      for (int i = 0; i < NUM_POOLS; i++) begin
        size_r[i]  <= '0;
        count_r[i] <= '0;
        base[i]    <= '0;
        head[i]    <= '0;
        fill[i]    <= '0;
        fresh[i]   <= '0;
      end
    end else begin
      if (ovalid && rsp.ready && (cfg_hit || state != S_FIN)) begin
        ovalid <= 1'b0;
      end
      if (cfg_hit) begin
        if (32'(cfg.index) < NUM_POOLS) begin
          size_r[PW'(cfg.index)] <= cfg.data;
        end else begin
          count_r[PW'(32'(cfg.index) - NUM_POOLS)] <= COUNT_W'(cfg.data);
        end
        for (int i = 0; i < NUM_POOLS; i++) begin
          head[i]  <= '0;
          fill[i]  <= '0;
          fresh[i] <= '0;
        end
        pidx  <= '0;
        acc   <= '0;
        state <= S_REB_MUL;
      end else begin
        unique case (state)
          S_IDLE: begin
            if (req.valid) begin
              want     <= req.request_size;
              fidx     <= req.free_index;
              bad_pool <= 32'(req.free_pool) >= NUM_POOLS;
              if (req.command == CMD_FREE) begin
                pidx  <= (PW+1)'(req.free_pool);
                state <= S_FREE;
              end else begin
                pidx  <= '0;
                state <= S_SCAN;
              end
            end
          end
          S_SCAN: begin
            if (scan_end) begin
              res_status <= ST_NO_BLOCK;
              res_offset <= '0;
              res_pool   <= '0;
              res_index  <= '0;
              state      <= S_FIN;
            end else if (use_fresh) begin
              idx      <= fresh[p];
              fresh[p] <= fresh[p] + 1'b1;
              state    <= S_MUL;
            end else if (use_ring) begin
              head[p] <= IW'(head_inc);
              fill[p] <= fill[p] - 1'b1;
              state   <= S_RDWAIT;
            end else begin
              pidx <= pidx + 1'b1;
            end
          end
          S_RDWAIT: begin
            idx   <= CW'(ring_rdata);
            state <= S_MUL;
          end
          S_MUL: begin
            prod  <= PR_W'(mul_a) * PR_W'(mul_b);
            state <= S_ADD;
          end
          S_ADD: begin
            res_status <= ST_DONE;
            res_offset <= OFFSET_W'(32'(base[p]) + 32'(prod) + HEADER_BYTES);
            res_pool   <= POOL_W'(p);
            res_index  <= INDEX_W'(32'(idx));
            state      <= S_FIN;
          end
          S_FREE: begin
            if (free_ok) begin
              fill[p] <= fill[p] + 1'b1;
            end
            res_status <= free_ok ? ST_DONE : ST_BAD_FREE;
            res_offset <= '0;
            res_pool   <= '0;
            res_index  <= '0;
            state      <= S_FIN;
          end
          S_FIN: begin
            if (!ovalid || rsp.ready) begin
              ovalid  <= 1'b1;
              ostatus <= res_status;
              ooffset <= res_offset;
              opool   <= res_pool;
              oindex  <= res_index;
              state   <= S_IDLE;
            end
          end
          S_REB_MUL: begin
            base[p] <= acc;
            prod    <= PR_W'(mul_a) * PR_W'(mul_b);
            state   <= S_REB_ADD;
          end
          S_REB_ADD: begin
            acc <= OFFSET_W'(32'(acc) + 32'(prod));
            if (32'(pidx) == NUM_POOLS - 1) begin
              state <= S_IDLE;
            end else begin
              pidx  <= pidx + 1'b1;
              state <= S_REB_MUL;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  assign req.ready         = (state == S_IDLE) && !cfg_hit;
  assign cfg.ready         = 1'b1;
  assign rsp.valid         = ovalid;
  assign rsp.status        = ostatus;
  assign rsp.block_offset  = ooffset;
  assign rsp.granted_pool  = opool;
  assign rsp.granted_index = oindex;

endmodule

FILE: hdl/mpba_check.sv
// Port-level assertions for the multi-pool block allocator, with bind.
module mpba_check import mpba_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] rsp_status,
  input logic [OFFSET_W-1:0] rsp_offset,
  input logic [POOL_W-1:0]   rsp_pool,
  input logic [INDEX_W-1:0]  rsp_index
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_offset))
    else $error("response word changed while stalled");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  a_busy_after_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && !req_ready |=> !req_ready)
    else $error("request ready during pool rebuild");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_DONE |->
      rsp_offset == '0 && rsp_pool == '0 && rsp_index == '0)
    else $error("failed result carries nonzero fields");

endmodule

bind multi_pool_block_allocator mpba_check u_mpba_check (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .cfg_valid(cfg.valid), .cfg_ready(cfg.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_status(rsp.status), .rsp_offset(rsp.block_offset),
  .rsp_pool(rsp.granted_pool), .rsp_index(rsp.granted_index)
);

FILE: sim/multi_pool_block_allocator_test.sv
// Testbench for the multi-pool block allocator: directed table, random traffic, config phases.
`timescale 1ns / 100ps

module multi_pool_block_allocator_test;
  import mpba_pkg::*;

  localparam int NP = NUM_POOLS_DEF;
  localparam int MB = MAX_BLOCKS_DEF;
  localparam int HB = HEADER_BYTES_DEF;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic                command;
    logic [SIZE_W-1:0]   request_size;
    logic [POOL_W-1:0]   free_pool;
    logic [INDEX_W-1:0]  free_index;
  } req_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] block_offset;
    logic [POOL_W-1:0]   granted_pool;
    logic [INDEX_W-1:0]  granted_index;
  } rsp_word_t;

  typedef struct packed {
    req_word_t word;
    logic      typed;
    rsp_word_t want;
  } table_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mpba_req_if req ();
  mpba_rsp_if rsp ();
  mpba_cfg_if cfg ();

  multi_pool_block_allocator dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // allocator shadow
  logic [SIZE_W-1:0]   pool_size [NP];
  logic [COUNT_W-1:0]  pool_count [NP];
  logic [INDEX_W-1:0]  ring [NP][MB];
  int                  head [NP];
  int                  fill [NP];
  int                  fresh [NP];
  logic [OFFSET_W-1:0] base [NP];
  logic [INDEX_W-1:0]  held [NP][$];

  rsp_word_t pending_rsp [$];
  int        errors = 0;
  int        cycles = 0;
  int        rsp_seen = 0;
  int        allocs_ok = 0;
  int        frees_ok = 0;
  int        send_idle = 0;

  function automatic int eff_count(int p);
    return pool_count[p] > MB ? MB : int'(pool_count[p]);
  endfunction

  function automatic int live_pools();
    int p;
    for (p = 0; p < NP; p++)
      if (pool_size[p] == 0) return p;
    return NP;
  endfunction

  function automatic void rebuild_pools();
    logic [OFFSET_W-1:0] b;
    b = '0;
    for (int p = 0; p < NP; p++) begin
      head[p] = 0;
      fill[p] = 0;
      fresh[p] = 0;
      held[p].delete();
      base[p] = b;
      b = OFFSET_W'(64'(b) + (64'(pool_size[p]) + HB) * eff_count(p));
    end
  endfunction

  function automatic rsp_word_t serve_request(req_word_t w);
    rsp_word_t r;
    int np, cnt, idx, tail;
    r = '0;
    np = live_pools();
    if (w.command == CMD_ALLOC) begin
      for (int p = 0; p < np; p++) begin
        cnt = eff_count(p);
        if (pool_size[p] < w.request_size) continue;
        if (fresh[p] < cnt) begin
          idx = fresh[p];
          fresh[p]++;
        end else if (fill[p] > 0) begin
          idx = ring[p][head[p]];
          head[p] = (head[p] + 1) % MB;
          fill[p]--;
        end else continue;
        r.block_offset = OFFSET_W'(64'(base[p]) + 64'(idx) * (64'(pool_size[p]) + HB) + HB);
        r.granted_pool = POOL_W'(p);
        r.granted_index = INDEX_W'(idx);
        held[p].push_back(INDEX_W'(idx));
        allocs_ok++;
        return r;
      end
      r.status = ST_NO_BLOCK;
      return r;
    end
    if (w.free_pool >= np) begin
      r.status = ST_BAD_FREE;
      return r;
    end
    cnt = eff_count(w.free_pool);
    if (w.free_index >= cnt || w.free_index >= fresh[w.free_pool]
        || (cnt - fresh[w.free_pool]) + fill[w.free_pool] >= cnt) begin
      r.status = ST_BAD_FREE;
      return r;
    end
    tail = (head[w.free_pool] + fill[w.free_pool]) % MB;
    ring[w.free_pool][tail] = w.free_index;
    fill[w.free_pool]++;
    for (int i = 0; i < held[w.free_pool].size(); i++)
      if (held[w.free_pool][i] == w.free_index) begin
        held[w.free_pool].delete(i);
        break;
      end
    frees_ok++;
    return r;
  endfunction

  int send_pct = 0;
  int stall_pct = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_word_t got, exp;
    if (!rst && rsp.valid && rsp.ready) begin
      got = '{rsp.status, rsp.block_offset, rsp.granted_pool, rsp.granted_index};
      rsp_seen++;
      if (pending_rsp.size() == 0) begin
        $display("%0t unexpected word %h", $time, got);
        errors++;
      end else begin
        exp = pending_rsp.pop_front();
        if (got.status !== exp.status) begin
          $display("%0t status exp %0d got %0d", $time, exp.status, got.status);
          errors++;
        end
        if (got.block_offset !== exp.block_offset) begin
          $display("%0t block_offset exp %0d got %0d", $time, exp.block_offset,
                   got.block_offset);
          errors++;
        end
        if (got.granted_pool !== exp.granted_pool) begin
          $display("%0t granted_pool exp %0d got %0d", $time, exp.granted_pool,
                   got.granted_pool);
          errors++;
        end
        if (got.granted_index !== exp.granted_index) begin
          $display("%0t granted_index exp %0d got %0d", $time, exp.granted_index,
                   got.granted_index);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else rsp.ready <= ($urandom_range(99) >= stall_pct);
  end

  // drive one register write; called at a falling edge, returns at a falling edge
  task automatic write_reg(int idx, int value);
    cfg.index <= CFG_IDX_W'(idx);
    cfg.data <= CFG_DATA_W'(value);
    cfg.valid <= 1'b1;
    do @(posedge clk); while (!cfg.ready);
    if (idx < NP) pool_size[idx] = SIZE_W'(value);
    else pool_count[idx - NP] = COUNT_W'(value);
    rebuild_pools();
    @(negedge clk);
  endtask

  task automatic drain();
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic configure(int s0, int s1, int s2, int s3, int c0, int c1, int c2, int c3);
    int v [2*NP];
    v = '{s0, s1, s2, s3, c0, c1, c2, c3};
    drain();
    for (int i = 0; i < 2*NP; i++) write_reg(i, v[i]);
    cfg.valid <= 1'b0;
  endtask

  // drive one word; called at a falling edge, returns at a falling edge
  task automatic send_word(req_word_t w, logic typed, rsp_word_t want);
    rsp_word_t pred;
    @(negedge clk);
    while ($urandom_range(99) < send_pct) begin
      send_idle++;
      @(negedge clk);
    end
    {req.command, req.request_size, req.free_pool, req.free_index} <= w;
    req.valid <= 1'b1;
    do @(posedge clk); while (!req.ready);
    pred = serve_request(w);
    if (typed && pred !== want) begin
      $display("%0t table row exp %h model %h", $time, want, pred);
      errors++;
    end
    pending_rsp.push_back(pred);
    @(negedge clk);
    req.valid <= 1'b0;
  endtask

  function automatic req_word_t alloc_word(int sz);
    return '{CMD_ALLOC, SIZE_W'(sz), POOL_W'($urandom), INDEX_W'($urandom)};
  endfunction

  function automatic req_word_t free_word(int p, int i);
    return '{CMD_FREE, SIZE_W'($urandom), POOL_W'(p), INDEX_W'(i)};
  endfunction

  function automatic rsp_word_t grant(int off, int p, int i);
    return '{ST_DONE, OFFSET_W'(off), POOL_W'(p), INDEX_W'(i)};
  endfunction

  task automatic random_traffic(int n);
    req_word_t w;
    int p, k, np;
    for (int i = 0; i < n; i++) begin
      np = live_pools();
      k = $urandom_range(99);
      if (k < 50) begin
        p = $urandom_range(np > 0 ? np - 1 : 0);
        w = alloc_word($urandom_range(4) == 0 ? $urandom_range(65535)
                       : $urandom_range(pool_size[p]));
      end else if (k < 85) begin
        p = $urandom_range(NP - 1);
        if (held[p].size() > 0) w = free_word(p, held[p][$urandom_range(held[p].size() - 1)]);
        else w = free_word(p, $urandom_range(255));
      end else w = free_word($urandom_range(NP - 1), $urandom_range(255));
      send_word(w, 1'b0, '0);
    end
  endtask

  table_row_t steps [$];
  int phase_sizes [5][8];

  initial begin
    req.valid = 1'b0;
    req.command = CMD_ALLOC;
    req.request_size = '0;
    req.free_pool = '0;
    req.free_index = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    rsp.ready = 1'b0;
    for (int p = 0; p < NP; p++) begin
      pool_size[p] = '0;
      pool_count[p] = '0;
    end
    rebuild_pools();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // after reset no pool is live
    steps.push_back('{alloc_word(0), 1'b1, '{ST_NO_BLOCK, '0, '0, '0}});
    steps.push_back('{free_word(0, 0), 1'b1, '{ST_BAD_FREE, '0, '0, '0}});
    foreach (steps[i]) send_word(steps[i].word, steps[i].typed, steps[i].want);
    steps.delete();

    configure(16, 100, 65535, 0, 2, 1, 300, 5);
    // pool1 base 48, pool2 base 156
    steps.push_back('{alloc_word(0), 1'b1, grant(8, 0, 0)});
    steps.push_back('{alloc_word(16), 1'b1, grant(32, 0, 1)});
    steps.push_back('{alloc_word(16), 1'b1, grant(56, 1, 0)});
    steps.push_back('{alloc_word(1), 1'b1, grant(164, 2, 0)});
    steps.push_back('{alloc_word(65535), 1'b1, grant(164 + 65543, 2, 1)});
    steps.push_back('{free_word(0, 1), 1'b1, grant(0, 0, 0)});
    steps.push_back('{free_word(0, 1), 1'b1, grant(0, 0, 0)});
    steps.push_back('{free_word(0, 2), 1'b1, '{ST_BAD_FREE, '0, '0, '0}});
    steps.push_back('{free_word(2, 200), 1'b1, '{ST_BAD_FREE, '0, '0, '0}});
    steps.push_back('{free_word(3, 0), 1'b1, '{ST_BAD_FREE, '0, '0, '0}});
    steps.push_back('{free_word(2, 255), 1'b1, '{ST_BAD_FREE, '0, '0, '0}});
    steps.push_back('{alloc_word(8), 1'b1, grant(32, 0, 1)});
    steps.push_back('{alloc_word(8), 1'b0, '0});
    steps.push_back('{free_word(1, 0), 1'b0, '0});
    steps.push_back('{free_word(1, 0), 1'b0, '0});
    steps.push_back('{free_word(0, 0), 1'b0, '0});
    steps.push_back('{free_word(0, 1), 1'b0, '0});
    steps.push_back('{alloc_word(3), 1'b0, '0});
    steps.push_back('{alloc_word(3), 1'b0, '0});
    foreach (steps[i]) send_word(steps[i].word, steps[i].typed, steps[i].want);

    phase_sizes[0] = '{24, 64, 512, 4096, 6, 5, 4, 3};
    phase_sizes[1] = '{65535, 65535, 65535, 65535, 256, 511, 256, 300};
    phase_sizes[2] = '{1, 2, 3, 0, 3, 2, 1, 7};
    phase_sizes[3] = '{8, 65535, 0, 200, 0, 4, 9, 9};
    phase_sizes[4] = '{32, 128, 1024, 65535, 2, 2, 256, 2};
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_pct = 0;  stall_pct = 0;  end
        1: begin send_pct = 57; stall_pct = 0;  end
        2: begin send_pct = 0;  stall_pct = 57; end
        default: begin send_pct = 10; stall_pct = 10; end
      endcase
      configure(phase_sizes[ph % 5][0], phase_sizes[ph % 5][1], phase_sizes[ph % 5][2],
                phase_sizes[ph % 5][3], phase_sizes[ph % 5][4], phase_sizes[ph % 5][5],
                phase_sizes[ph % 5][6], phase_sizes[ph % 5][7]);
      random_traffic(ph == 1 ? 40 : 120);
    end
    send_pct = 0;
    stall_pct = 0;
    drain();

    $display("Checked %0d responses: %0d grants, %0d accepted frees over 9 pool setups.",
             rsp_seen, allocs_ok, frees_ok);
    $display("Sender idled %0d cycles; errors %0d.", send_idle, errors);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
